@@ hdl/test_id_selector_rewriter_defines.svh @@
// ----------------------------------------------------------------------------
// test_id_selector_rewriter_defines
// Assertion macros shared by the selector rewriter.
// ----------------------------------------------------------------------------
`ifndef TEST_ID_SELECTOR_REWRITER_DEFINES_SVH
`define TEST_ID_SELECTOR_REWRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TIDSR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("selector rewriter check failed");

// next-cycle implication, checked out of reset
`define TIDSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("selector rewriter check failed");

`endif

@@ hdl/tidsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tidsr_pkg
// Types, constants and byte classes of the selector rewriter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tidsr_pkg;

   localparam int NAME_MAX_BYTES_DEFAULT = 16;
   localparam int NAME_BYTES_STORED      = 16;
   localparam int NAME_IDX_W             = 4;
   localparam int NAME_LEN_W             = 5;
   localparam int CSR_ADDR_W             = 5;
   localparam int CSR_DATA_W             = 64;

   localparam logic [63:0] NAME_LOW_RESET  = 64'h7365_742d_6174_6164; // "data-tes"
   localparam logic [63:0] NAME_HIGH_RESET = 64'h0000_0000_0064_6974; // "tid"
   localparam logic [NAME_LEN_W-1:0] NAME_LENGTH_RESET = 5'd11;

   // register index, taken from paddr[4:3]
   localparam logic [1:0] REG_NAME_LOW    = 2'd0;
   localparam logic [1:0] REG_NAME_HIGH   = 2'd1;
   localparam logic [1:0] REG_NAME_LENGTH = 2'd2;

   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_EQUALS = 8'h3d;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] LEVEL_MAX = 8'hff;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_QUOTE,
      ST_PRE_CLOSE,
      ST_COPY,
      ST_OPEN,
      ST_NAME,
      ST_EQUALS,
      ST_QUOTE,
      ST_POST_QUOTE,
      ST_POST_CLOSE
   } state_type;

   typedef enum logic [2:0] {
      SEL_BYTE,
      SEL_OPEN,
      SEL_NAME,
      SEL_EQUALS,
      SEL_QUOTE,
      SEL_CLOSE
   } sel_type;

   // what one request expands into
   typedef struct packed {
      logic pre_close;
      logic expand;
      logic post_close;
   } plan_type;

   typedef struct packed {
      logic    accept;
      logic    emit;
      sel_type sel;
      logic    run_last;
      logic    name_clear;
      logic    name_step;
   } cmd_type;

   typedef struct packed {
      logic     slot_free;
      plan_type new_plan;
      plan_type plan;
      logic     name_empty;
      logic     name_last;
   } status_type;

   function automatic logic is_id_byte(input logic [7:0] b);
      is_id_byte = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
                   (b >= 8'h30 && b <= 8'h39) || b == CH_DASH || b == CH_UNDER;
   endfunction

   function automatic logic begins_compound(input logic [7:0] b);
      begins_compound = b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
                        b == CH_COMMA || b == CH_LPAREN;
   endfunction

endpackage

`default_nettype wire

@@ hdl/tidsr_csr.sv @@
// ----------------------------------------------------------------------------
// tidsr_csr
// Configuration registers: attribute name bytes and name length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tidsr_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [tidsr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [tidsr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [tidsr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                       csr_pready,
   output logic      [8*tidsr_pkg::NAME_BYTES_STORED-1:0] name_chars,
   output logic      [tidsr_pkg::NAME_LEN_W-1:0]      name_length
);

   logic [63:0]                        name_low_ff,    name_low_in;
   logic [63:0]                        name_high_ff,   name_high_in;
   logic [tidsr_pkg::NAME_LEN_W-1:0]   name_length_ff, name_length_in;
   logic                               write_en;
   logic [1:0]                         reg_idx;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_comb begin
      name_low_in    = name_low_ff;
      name_high_in   = name_high_ff;
      name_length_in = name_length_ff;
      if (write_en) begin
         unique case (reg_idx)
            tidsr_pkg::REG_NAME_LOW:    name_low_in    = csr_pwdata;
            tidsr_pkg::REG_NAME_HIGH:   name_high_in   = csr_pwdata;
            tidsr_pkg::REG_NAME_LENGTH: name_length_in = csr_pwdata[tidsr_pkg::NAME_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff    <= tidsr_pkg::NAME_LOW_RESET;
         name_high_ff   <= tidsr_pkg::NAME_HIGH_RESET;
         name_length_ff <= tidsr_pkg::NAME_LENGTH_RESET;
      end else begin
         name_low_ff    <= name_low_in;
         name_high_ff   <= name_high_in;
         name_length_ff <= name_length_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tidsr_pkg::REG_NAME_LOW:    csr_prdata = name_low_ff;
         tidsr_pkg::REG_NAME_HIGH:   csr_prdata = name_high_ff;
         tidsr_pkg::REG_NAME_LENGTH:
            csr_prdata = {{(tidsr_pkg::CSR_DATA_W-tidsr_pkg::NAME_LEN_W){1'b0}}, name_length_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign name_chars  = {name_high_ff, name_low_ff};
   assign name_length = name_length_ff;

endmodule

`default_nettype wire

@@ hdl/tidsr_datapath.sv @@
// ----------------------------------------------------------------------------
// tidsr_datapath
// Selector state, request register, byte selection and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tidsr_datapath #(
   parameter int NAME_MAX_BYTES = tidsr_pkg::NAME_MAX_BYTES_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire tidsr_pkg::cmd_type                        cmd,
   output tidsr_pkg::status_type                          status,
   input  wire logic [7:0]                                req_in_byte,
   input  wire logic                                      req_in_final,
   input  wire logic [8*tidsr_pkg::NAME_BYTES_STORED-1:0] name_chars,
   input  wire logic [tidsr_pkg::NAME_LEN_W-1:0]          name_length,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic      [7:0]                                rsp_out_byte,
   output logic                                           rsp_run_last,
   output logic                                           rsp_selector_done
);

   localparam logic [tidsr_pkg::NAME_LEN_W-1:0] MAX_LEN = tidsr_pkg::NAME_LEN_W'(NAME_MAX_BYTES);

   logic                              in_identifier_ff,  in_identifier_in;
   logic                              compound_start_ff, compound_start_in;
   logic [7:0]                        bracket_level_ff,  bracket_level_in;
   logic [7:0]                        byte_ff;
   logic                              final_ff;
   tidsr_pkg::plan_type               plan_ff;
   logic [tidsr_pkg::NAME_IDX_W-1:0]  name_idx_ff,       name_idx_in;
   logic                              rsp_valid_ff,      rsp_valid_in;
   logic [7:0]                        rsp_byte_ff,       rsp_byte_in;
   logic                              rsp_last_ff;
   logic                              rsp_done_ff;

   tidsr_pkg::plan_type               plan_now;
   logic                              id_run;
   logic                              normal;
   logic [7:0]                        level_next;
   logic                              in_id_next;
   logic                              cs_next;
   logic [tidsr_pkg::NAME_LEN_W-1:0]  eff_len;
   logic [7:0]                        name_byte;

   // ---- state update for the request on the input ----
   always_comb begin
      id_run = in_identifier_ff && tidsr_pkg::is_id_byte(req_in_byte);
      normal = !id_run;

      level_next = bracket_level_ff;
      if (normal) begin
         if (req_in_byte == tidsr_pkg::CH_LBRACK) begin
            if (bracket_level_ff != tidsr_pkg::LEVEL_MAX)
               level_next = bracket_level_ff + 8'd1;
         end else if (req_in_byte == tidsr_pkg::CH_RBRACK && bracket_level_ff != 8'd0) begin
            level_next = bracket_level_ff - 8'd1;
         end
      end

      plan_now.pre_close = in_identifier_ff && !id_run;
      plan_now.expand    = normal && req_in_byte == tidsr_pkg::CH_AT &&
                           compound_start_ff && level_next == 8'd0;
      in_id_next         = id_run || plan_now.expand;
      cs_next            = compound_start_ff;
      if (normal)
         cs_next = plan_now.expand ? 1'b0 : tidsr_pkg::begins_compound(req_in_byte);
      plan_now.post_close = req_in_final && in_id_next;

      in_identifier_in  = in_identifier_ff;
      compound_start_in = compound_start_ff;
      bracket_level_in  = bracket_level_ff;
      if (cmd.accept) begin
         if (req_in_final) begin
            // selector ends: back to the start-of-stream state
            in_identifier_in  = 1'b0;
            compound_start_in = 1'b1;
            bracket_level_in  = 8'd0;
         end else begin
            in_identifier_in  = in_id_next;
            compound_start_in = cs_next;
            bracket_level_in  = level_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_identifier_ff  <= 1'b0;
         compound_start_ff <= 1'b1;
         bracket_level_ff  <= 8'd0;
      end else begin
         in_identifier_ff  <= in_identifier_in;
         compound_start_ff <= compound_start_in;
         bracket_level_ff  <= bracket_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff  <= req_in_byte;
         final_ff <= req_in_final;
         plan_ff  <= plan_now;
      end
   end

   // ---- attribute name walk ----
   assign eff_len   = (name_length > MAX_LEN) ? MAX_LEN : name_length;
   assign name_byte = name_chars[{name_idx_ff, 3'b000} +: 8];

   always_comb begin
      name_idx_in = name_idx_ff;
      if (cmd.name_clear)
         name_idx_in = '0;
      else if (cmd.name_step)
         name_idx_in = name_idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      name_idx_ff <= name_idx_in;
   end

   // ---- result register ----
   always_comb begin
      unique case (cmd.sel)
         tidsr_pkg::SEL_BYTE:   rsp_byte_in = byte_ff;
         tidsr_pkg::SEL_OPEN:   rsp_byte_in = tidsr_pkg::CH_LBRACK;
         tidsr_pkg::SEL_NAME:   rsp_byte_in = name_byte;
         tidsr_pkg::SEL_EQUALS: rsp_byte_in = tidsr_pkg::CH_EQUALS;
         tidsr_pkg::SEL_QUOTE:  rsp_byte_in = tidsr_pkg::CH_QUOTE;
         tidsr_pkg::SEL_CLOSE:  rsp_byte_in = tidsr_pkg::CH_RBRACK;
         default:               rsp_byte_in = byte_ff;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= cmd.run_last;
         rsp_done_ff <= cmd.run_last && final_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_run_last      = rsp_last_ff;
   assign rsp_selector_done = rsp_done_ff;

   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign status.new_plan   = plan_now;
   assign status.plan       = plan_ff;
   assign status.name_empty = eff_len == '0;
   assign status.name_last  = {1'b0, name_idx_ff} == eff_len - 1'b1;

endmodule

`default_nettype wire

@@ hdl/tidsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tidsr_ctrl
// Sequencer: takes a request and steps through the bytes it expands into.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tidsr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tidsr_pkg::status_type status,
   output tidsr_pkg::cmd_type         cmd
);

   tidsr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= tidsr_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.emit       = 1'b0;
      cmd.sel        = tidsr_pkg::SEL_BYTE;
      cmd.run_last   = 1'b0;
      cmd.name_clear = 1'b0;
      cmd.name_step  = 1'b0;
      req_stall      = state_ff != tidsr_pkg::ST_IDLE;

      unique case (state_ff)
         tidsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.new_plan.pre_close)
                  state_in = tidsr_pkg::ST_PRE_QUOTE;
               else if (status.new_plan.expand)
                  state_in = tidsr_pkg::ST_OPEN;
               else
                  state_in = tidsr_pkg::ST_COPY;
            end
         end
         tidsr_pkg::ST_PRE_QUOTE: begin
            cmd.sel = tidsr_pkg::SEL_QUOTE;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = tidsr_pkg::ST_PRE_CLOSE;
            end
         end
         tidsr_pkg::ST_PRE_CLOSE: begin
            cmd.sel = tidsr_pkg::SEL_CLOSE;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = status.plan.expand ? tidsr_pkg::ST_OPEN : tidsr_pkg::ST_COPY;
            end
         end
         tidsr_pkg::ST_COPY: begin
            cmd.sel      = tidsr_pkg::SEL_BYTE;
            cmd.run_last = !status.plan.post_close;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = status.plan.post_close ? tidsr_pkg::ST_POST_QUOTE
                                                 : tidsr_pkg::ST_IDLE;
            end
         end
         tidsr_pkg::ST_OPEN: begin
            cmd.sel = tidsr_pkg::SEL_OPEN;
            if (status.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.name_clear = 1'b1;
               state_in = status.name_empty ? tidsr_pkg::ST_EQUALS : tidsr_pkg::ST_NAME;
            end
         end
         tidsr_pkg::ST_NAME: begin
            cmd.sel = tidsr_pkg::SEL_NAME;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.name_last)
                  state_in = tidsr_pkg::ST_EQUALS;
               else
                  cmd.name_step = 1'b1;
            end
         end
         tidsr_pkg::ST_EQUALS: begin
            cmd.sel = tidsr_pkg::SEL_EQUALS;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = tidsr_pkg::ST_QUOTE;
            end
         end
         tidsr_pkg::ST_QUOTE: begin
            cmd.sel      = tidsr_pkg::SEL_QUOTE;
            cmd.run_last = !status.plan.post_close;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = status.plan.post_close ? tidsr_pkg::ST_POST_QUOTE
                                                 : tidsr_pkg::ST_IDLE;
            end
         end
         tidsr_pkg::ST_POST_QUOTE: begin
            cmd.sel = tidsr_pkg::SEL_QUOTE;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = tidsr_pkg::ST_POST_CLOSE;
            end
         end
         tidsr_pkg::ST_POST_CLOSE: begin
            cmd.sel      = tidsr_pkg::SEL_CLOSE;
            cmd.run_last = 1'b1;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = tidsr_pkg::ST_IDLE;
            end
         end
         default: state_in = tidsr_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/test_id_selector_rewriter.sv @@
// Selector rewriter. Each request carries one selector byte; the block copies
// it, or, for an '@' at the start of a compound outside brackets, expands it
// into '[', the configured attribute name, '=' and a double quote, with the id
// bytes that follow closed by '"' and ']'. A request is taken in the idle
// state; the sequencer then emits its result bytes one per cycle whenever
// the output register is free, and holds req_stall until the last result
// of the current request is in the output register, which lets the next
// request be taken while that result still waits on rsp_stall.
// ----------------------------------------------------------------------------
// test_id_selector_rewriter
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "test_id_selector_rewriter_defines.svh"

module test_id_selector_rewriter #(
   parameter int NAME_MAX_BYTES = tidsr_pkg::NAME_MAX_BYTES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_in_byte,
   input  wire logic                              req_in_final,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [7:0]                        rsp_out_byte,
   output logic                                   rsp_run_last,
   output logic                                   rsp_selector_done,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tidsr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [tidsr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [tidsr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   tidsr_pkg::cmd_type                        cmd;
   tidsr_pkg::status_type                     status;
   logic [8*tidsr_pkg::NAME_BYTES_STORED-1:0] name_chars;
   logic [tidsr_pkg::NAME_LEN_W-1:0]          name_length;

   tidsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .name_chars  (name_chars),
      .name_length (name_length)
   );

   tidsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tidsr_datapath #(
      .NAME_MAX_BYTES (NAME_MAX_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_in_byte       (req_in_byte),
      .req_in_final      (req_in_final),
      .name_chars        (name_chars),
      .name_length       (name_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_selector_done (rsp_selector_done)
   );

   // a taken request always produces at least one result before the next one
   `TIDSR_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall)
   // the result register is never overwritten while it holds an untaken result
   `TIDSR_ASSERT_IMPL(a_emit_into_free_slot, clock, reset, cmd.emit, status.slot_free)
   // end of selector only ever marks the last result of its request
   `TIDSR_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_valid && rsp_selector_done, rsp_run_last)

endmodule

`default_nettype wire

@@ tb/test_id_selector_rewriter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// test_id_selector_rewriter_tb
// Self-checking bench for the selector rewriter: directed selectors cover the
// id-expansion corners and bracket nesting, then random selectors run under
// several attribute names while both sides of the stream idle and stall.
// ----------------------------------------------------------------------------

class rewrite_scoreboard;
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       selector_done;
   } rewrite_result_type;

   logic [63:0]        name_low;
   logic [63:0]        name_high;
   logic [4:0]         name_len;
   logic               in_id_run;
   logic               at_compound;
   logic [7:0]         depth;
   rewrite_result_type expected_output[$];
   rewrite_result_type run[$];
   int                 errors;

   function new();
      name_low  = tidsr_pkg::NAME_LOW_RESET;
      name_high = tidsr_pkg::NAME_HIGH_RESET;
      name_len  = tidsr_pkg::NAME_LENGTH_RESET;
      errors    = 0;
      clear_selector();
   endfunction

   function void clear_selector();
      in_id_run   = 1'b0;
      at_compound = 1'b1;
      depth       = 8'd0;
   endfunction

   function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
         tidsr_pkg::REG_NAME_LOW:    name_low = value;
         tidsr_pkg::REG_NAME_HIGH:   name_high = value;
         tidsr_pkg::REG_NAME_LENGTH: name_len = value[4:0];
         default: ;
      endcase
   endfunction

   function logic is_id_char(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == tidsr_pkg::CH_DASH ||
             b == tidsr_pkg::CH_UNDER;
   endfunction

   function logic starts_compound(logic [7:0] b);
      return b == tidsr_pkg::CH_SPACE || b == tidsr_pkg::CH_TAB ||
             b == tidsr_pkg::CH_LF || b == tidsr_pkg::CH_CR ||
             b == tidsr_pkg::CH_COMMA || b == tidsr_pkg::CH_LPAREN;
   endfunction

   function void emit_char(logic [7:0] b);
      rewrite_result_type r;
      r.out_byte      = b;
      r.run_last      = 1'b0;
      r.selector_done = 1'b0;
      run = {run, r};
   endfunction

   // expected output bytes for one accepted request
   function void note_request(logic [7:0] b, logic fin);
      rewrite_result_type tail;
      logic               copy_path;
      int                 n;
      int                 i;
      run.delete();
      copy_path = 1'b1;
      if (in_id_run) begin
         if (is_id_char(b)) begin
            emit_char(b);
            copy_path = 1'b0;
         end else begin
            emit_char(tidsr_pkg::CH_QUOTE);
            emit_char(tidsr_pkg::CH_RBRACK);
            in_id_run = 1'b0;
         end
      end
      if (copy_path) begin
         if (b == tidsr_pkg::CH_LBRACK) begin
            if (depth != tidsr_pkg::LEVEL_MAX) depth = depth + 8'd1;
         end else if (b == tidsr_pkg::CH_RBRACK && depth != 8'd0) begin
            depth = depth - 8'd1;
         end
         if (b == tidsr_pkg::CH_AT && at_compound && depth == 8'd0) begin
            emit_char(tidsr_pkg::CH_LBRACK);
            n = (name_len > tidsr_pkg::NAME_MAX_BYTES_DEFAULT) ?
                tidsr_pkg::NAME_MAX_BYTES_DEFAULT : name_len;
            for (i = 0; i < n; i++)
               emit_char(i < 8 ? name_low[8*i +: 8] : name_high[8*(i-8) +: 8]);
            emit_char(tidsr_pkg::CH_EQUALS);
            emit_char(tidsr_pkg::CH_QUOTE);
            in_id_run   = 1'b1;
            at_compound = 1'b0;
         end else begin
            emit_char(b);
            at_compound = starts_compound(b);
         end
      end
      // selector ends inside an id run: close it
      if (fin && in_id_run) begin
         emit_char(tidsr_pkg::CH_QUOTE);
         emit_char(tidsr_pkg::CH_RBRACK);
      end
      tail = run[run.size()-1];
      tail.run_last      = 1'b1;
      tail.selector_done = fin;
      run[run.size()-1]  = tail;
      if (fin) clear_selector();
      expected_output = {expected_output, run};
   endfunction

   function void check_result(logic [7:0] b, logic rl, logic sd);
      rewrite_result_type want;
      if (expected_output.size() == 0) begin
         $display("%0t: unexpected result, out_byte %h", $time, b);
         errors++;
         return;
      end
      want = expected_output.pop_front();
      if (want.out_byte !== b) begin
         $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, b);
         errors++;
      end
      if (want.run_last !== rl) begin
         $display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
         errors++;
      end
      if (want.selector_done !== sd) begin
         $display("%0t: selector_done expected %b actual %b", $time, want.selector_done, sd);
         errors++;
      end
   endfunction
endclass

module test_id_selector_rewriter_tb;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ITEMS = 12;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_in_byte = 8'd0;
   logic                             req_in_final = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_run_last;
   logic                             rsp_selector_done;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [tidsr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tidsr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tidsr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   rewrite_scoreboard sb = new();
   int                items_sent = 0;
   int                burst_left = 0;
   bit                hold_off_request = 1'b0;

   test_id_selector_rewriter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_in_final      (req_in_final),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_selector_done (rsp_selector_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_in_byte, req_in_final);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_byte, rsp_run_last, rsp_selector_done);
      end
   end

   // output side stall pattern, with one long hold-off on request
   initial begin : receiver
      int mode;
      int span;
      int cyc;
      cyc = 0;
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span) begin
               if (hold_off_request) break;
               cyc++;
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= (cyc % 3) == 0;
                  default: rsp_stall <= $urandom_range(0, 3) != 0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_in_final <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      // let the monitor note the last accepted request first
      @(posedge clock);
      while (sb.expected_output.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 5))
         0: return tidsr_pkg::CH_SPACE;
         1: return tidsr_pkg::CH_TAB;
         2: return tidsr_pkg::CH_LF;
         3: return tidsr_pkg::CH_CR;
         4: return tidsr_pkg::CH_COMMA;
         default: return tidsr_pkg::CH_LPAREN;
      endcase
   endfunction

   function automatic logic [7:0] pick_id_char();
      int r;
      r = $urandom_range(0, 63);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return (r == 62) ? tidsr_pkg::CH_DASH : tidsr_pkg::CH_UNDER;
   endfunction

   // mostly well-formed selectors with id references
   task automatic send_selector(input int tokens);
      logic [7:0] text[$];
      int         n;
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               text = {text, pick_separator(), tidsr_pkg::CH_AT};
               n = $urandom_range(0, 5);
               repeat (n) text = {text, pick_id_char()};
            end
            3: begin
               text = {text, tidsr_pkg::CH_AT};
               n = $urandom_range(0, 3);
               repeat (n) text = {text, pick_id_char()};
            end
            4: text = {text, pick_separator()};
            5: text = {text, tidsr_pkg::CH_LBRACK};
            6: text = {text, tidsr_pkg::CH_RBRACK};
            7: text = {text, pick_id_char()};
            8: text = {text, 8'($urandom_range(0, 255))};
            default: text = {text, 8'(".")};
         endcase
      end
      foreach (text[i]) send_request(text[i], i == text.size() - 1);
   endtask

   task automatic run_random_phase(input int quota);
      int target;
      int n;
      target = items_sent + quota;
      while (items_sent < target) begin
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) send_request(8'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            send_selector($urandom_range(1, 4));
         end
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // id bytes of every class, run closed by a separator, final '@'
      send_text("@aZ09-_ (@");
      // '@' inside brackets and mid-compound, empty id, final id byte
      send_text("[@]@,@.\t@q");
      send_request(8'h00, 1'b0);
      send_request(tidsr_pkg::CH_LF, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(tidsr_pkg::CH_CR, 1'b0);
      send_request(tidsr_pkg::CH_AT, 1'b0);
      send_request("k", 1'b0);
      send_request(8'hff, 1'b1);

      // nested brackets keep '@' literal until every level is closed
      send_text("[[ @] @] @a");
      // a close at depth zero leaves the depth at zero
      send_text("]] @b");
      wait_for_drain();

      write_register(tidsr_pkg::REG_NAME_LOW, '1);
      write_register(tidsr_pkg::REG_NAME_HIGH, '0);
      write_register(tidsr_pkg::REG_NAME_LENGTH, 64'd0);
      hold_off_request = 1'b1;
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();

      write_register(tidsr_pkg::REG_NAME_LOW, {$urandom, $urandom});
      write_register(tidsr_pkg::REG_NAME_HIGH, {$urandom, $urandom});
      write_register(tidsr_pkg::REG_NAME_LENGTH, 64'd16);
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();

      write_register(tidsr_pkg::REG_NAME_HIGH, '1);
      write_register(tidsr_pkg::REG_NAME_LENGTH, 64'd31);
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();

      write_register(REG_UNUSED, {$urandom, $urandom});
      write_register(tidsr_pkg::REG_NAME_LOW, '0);
      write_register(tidsr_pkg::REG_NAME_LENGTH, 64'd17);
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();

      write_register(tidsr_pkg::REG_NAME_LOW, {$urandom, $urandom});
      write_register(tidsr_pkg::REG_NAME_HIGH, {$urandom, $urandom});
      write_register(tidsr_pkg::REG_NAME_LENGTH, 64'($urandom_range(0, 16)));
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_output.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tidsr_pkg.sv
hdl/tidsr_csr.sv
hdl/tidsr_datapath.sv
hdl/tidsr_ctrl.sv
hdl/test_id_selector_rewriter.sv
tb/test_id_selector_rewriter_tb.sv
